// ----- design/asbp_pkg.sv -----
// Shared types and constants for the sample batch packetizer.
// No dependencies; imported by the top level and the checker.
package asbp_pkg;

  // Store depth and the widths that follow from it
  localparam int BATCH_DEPTH = 50;
  localparam int FILL_W      = $clog2(BATCH_DEPTH + 1);
  localparam int ADDR_W      = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int SIZE_W      = 6;
  localparam int CMP_W       = (FILL_W > SIZE_W) ? FILL_W : SIZE_W;

  // Field widths
  localparam int TIME_W    = 32;
  localparam int CODE_W    = 24;
  localparam int VERSION_W = 8;
  localparam int COUNT_W   = 6;
  localparam int SEQ_W     = 32;
  localparam int OFFSET_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_BATCH_SIZE       = 2'd0;
  localparam cfg_idx_t REG_PROTOCOL_VERSION = 2'd1;

  localparam logic [SIZE_W-1:0]    BATCH_SIZE_RST       = 6'd50;
  localparam logic [VERSION_W-1:0] PROTOCOL_VERSION_RST = 8'd1;

  // Rounded division by 1000: (d + 500) / 1000 = ((d + 500) >> 3) / 125,
  // and x / 125 = (x * ceil(2^37 / 125)) >> 37, exact for x below 2^30.
  localparam logic [TIME_W:0] ROUND_BIAS  = 33'd500;
  localparam int              DIV_IN_W    = 30;
  localparam int              RECIP_W     = 31;
  localparam int              PROD_W      = DIV_IN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP    = 31'd1099511628;
  localparam int              RECIP_SHIFT = 37;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [CODE_W-1:0]   first;
    logic [CODE_W-1:0]   second;
  } record_t;

  localparam int REC_W = $bits(record_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_STORE,
    ST_HDR,
    ST_RD,
    ST_EMIT
  } state_t;

endpackage

// ----- design/asbp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module asbp_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 50,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/adc_sample_batch_packetizer.sv -----
// Top level of the sample batch packetizer: frame intake, offset arithmetic,
// record store and packet flush. Depends on asbp_pkg and asbp_ram.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | in        | in_valid / in_stall | frame_time_us, first_code, second_code,
//          |           |                     | conversion_ok
//  out_    | out       | out_valid/out_stall | item_kind, version_byte, record_count,
//          |           |                     | sequence_number, offset_ms, first/second_value, last
//  cfg_    | in        | cfg_we              | cfg_index, cfg_wdata (batch_size, protocol_version)
//
// A dropped frame is taken in the idle state and discarded; a good frame passes
// through accept, reciprocal multiply and store write. A flush emits a header, then
// reads and emits each record in turn, as the record RAM has a registered read. Reset
// clears the counters and needs no clearing pass: a record is only read after it was
// written in the same batch. A stall on the output holds the pending request in the
// output register; the flush waits on it.
module adc_sample_batch_packetizer
  import asbp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [TIME_W-1:0]           in_frame_time_us,
  input  logic [CODE_W-1:0]           in_first_code,
  input  logic [CODE_W-1:0]           in_second_code,
  input  logic                        in_conversion_ok,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_item_kind,
  output logic [VERSION_W-1:0]        out_version_byte,
  output logic [COUNT_W-1:0]          out_record_count,
  output logic [SEQ_W-1:0]            out_sequence_number,
  output logic [OFFSET_W-1:0]         out_offset_ms,
  output logic signed [CODE_W-1:0]    out_first_value,
  output logic signed [CODE_W-1:0]    out_second_value,
  output logic                        out_last,

  input  logic                        cfg_we,
  input  cfg_idx_t                    cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata
);

  // Control state
  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Configuration
  logic [SIZE_W-1:0]    batch_size_r;
  logic [VERSION_W-1:0] version_r;

  // Datapath
  logic [DIV_IN_W-1:0] n3_r, n3_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [CODE_W-1:0]   c1_r, c1_nxt;
  logic [CODE_W-1:0]   c2_r, c2_nxt;

  // Output register
  logic                     kind_r, kind_nxt;
  logic [VERSION_W-1:0]     ver_r, ver_nxt;
  logic [COUNT_W-1:0]       cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]         oseq_r, oseq_nxt;
  logic [OFFSET_W-1:0]      off_r, off_nxt;
  logic [CODE_W-1:0]        v1_r, v1_nxt;
  logic [CODE_W-1:0]        v2_r, v2_nxt;
  logic                     last_r, last_nxt;

  // Record RAM
  logic                ram_wr_en;
  logic                ram_rd_en;
  record_t             ram_wr_rec;
  logic [REC_W-1:0]    ram_rd_data;
  record_t             ram_rd_rec;

  logic [CMP_W-1:0]    eff_size;
  logic [CMP_W-1:0]    bs_ext;
  logic [FILL_W-1:0]   fill_inc;
  logic [TIME_W-1:0]   diff;
  logic [TIME_W:0]     biased;
  logic                slot_free;
  logic                rec_is_last;

  asbp_ram #(
    .WIDTH  (REC_W),
    .DEPTH  (BATCH_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (ram_wr_rec),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  assign ram_rd_rec = record_t'(ram_rd_data);

  // Clamp the batch size: zero acts as one, anything past the store as its depth
  always_comb begin
    bs_ext = CMP_W'(batch_size_r);
    priority if (bs_ext == '0) begin
      eff_size = CMP_W'(1);
    end else if (bs_ext > CMP_W'(BATCH_DEPTH)) begin
      eff_size = CMP_W'(BATCH_DEPTH);
    end else begin
      eff_size = bs_ext;
    end
  end

  assign fill_inc    = FILL_W'(fill_r + 1'b1);
  assign slot_free   = !out_valid_r || !out_stall;
  assign rec_is_last = (FILL_W'(rd_idx_r) + FILL_W'(1)) == fill_r;
  assign ram_wr_rec  = '{offset: prod_r[RECIP_SHIFT +: OFFSET_W], first: c1_r, second: c2_r};

  // Offset from the batch's first frame; the first frame of a batch starts at zero
  assign diff   = (fill_r == '0) ? '0 : (in_frame_time_us - start_r);
  assign biased = {1'b0, diff} + ROUND_BIAS;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    start_nxt     = start_r;
    seq_nxt       = seq_r;
    rd_idx_nxt    = rd_idx_r;
    n3_nxt        = n3_r;
    prod_nxt      = prod_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;

    // Drop the pending request once taken
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    ver_nxt       = ver_r;
    cnt_nxt       = cnt_r;
    oseq_nxt      = oseq_r;
    off_nxt       = off_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    last_nxt      = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_conversion_ok) begin
          if (fill_r == '0) begin
            start_nxt = in_frame_time_us;
          end
          n3_nxt    = biased[TIME_W:3];
          c1_nxt    = in_first_code;
          c2_nxt    = in_second_code;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(n3_r) * PROD_W'(RECIP);
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        ram_wr_en = 1'b1;
        fill_nxt  = fill_inc;
        if (CMP_W'(fill_inc) >= eff_size) begin
          state_nxt = ST_HDR;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b0;
          ver_nxt       = version_r;
          cnt_nxt       = COUNT_W'(fill_r);
          oseq_nxt      = seq_r;
          off_nxt       = '0;
          v1_nxt        = '0;
          v2_nxt        = '0;
          last_nxt      = 1'b0;
          rd_idx_nxt    = '0;
          state_nxt     = ST_RD;
        end
      end
      ST_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Read data holds in the RAM output register until the next read
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = 1'b1;
          ver_nxt       = '0;
          cnt_nxt       = '0;
          oseq_nxt      = '0;
          off_nxt       = ram_rd_rec.offset;
          v1_nxt        = ram_rd_rec.first;
          v2_nxt        = ram_rd_rec.second;
          last_nxt      = rec_is_last;
          if (rec_is_last) begin
            seq_nxt   = seq_r + 1'b1;
            fill_nxt  = '0;
            start_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
            state_nxt  = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      start_r     <= '0;
      seq_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      start_r     <= start_nxt;
      seq_r       <= seq_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_size_r <= BATCH_SIZE_RST;
      version_r    <= PROTOCOL_VERSION_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_BATCH_SIZE) begin
        batch_size_r <= cfg_wdata[SIZE_W-1:0];
      end else if (cfg_index == REG_PROTOCOL_VERSION) begin
        version_r <= cfg_wdata[VERSION_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n3_r   <= n3_nxt;
    prod_r <= prod_nxt;
    c1_r   <= c1_nxt;
    c2_r   <= c2_nxt;
    kind_r <= kind_nxt;
    ver_r  <= ver_nxt;
    cnt_r  <= cnt_nxt;
    oseq_r <= oseq_nxt;
    off_r  <= off_nxt;
    v1_r   <= v1_nxt;
    v2_r   <= v2_nxt;
    last_r <= last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_item_kind       = kind_r;
  assign out_version_byte    = ver_r;
  assign out_record_count    = cnt_r;
  assign out_sequence_number = oseq_r;
  assign out_offset_ms       = off_r;
  assign out_first_value     = v1_r;
  assign out_second_value    = v2_r;
  assign out_last            = last_r;

endmodule

// ----- design/asbp_checker.sv -----
// Port-level checker for the sample batch packetizer, bound to the top level.
// Depends on asbp_pkg.
module asbp_checker
  import asbp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_item_kind,
  input logic [SEQ_W-1:0]     out_sequence_number,
  input logic [OFFSET_W-1:0]  out_offset_ms,
  input logic                 out_last
);

  logic             expect_hdr_r;
  logic             seen_hdr_r;
  logic [SEQ_W-1:0] last_seq_r;
  logic             out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_hdr_r <= 1'b1;
      seen_hdr_r   <= 1'b0;
      last_seq_r   <= '0;
    end else if (out_take) begin
      if (!out_item_kind) begin
        expect_hdr_r <= 1'b0;
        seen_hdr_r   <= 1'b1;
        last_seq_r   <= out_sequence_number;
      end else if (out_last) begin
        expect_hdr_r <= 1'b1;
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item_kind) && $stable(out_last)
      && $stable(out_offset_ms))
    else $error("stalled result request changed");

  a_packet_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_kind == !expect_hdr_r))
    else $error("header and records out of order");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind |-> !out_last && out_offset_ms == '0)
    else $error("header carries record fields");

  a_seq_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind && seen_hdr_r |-> out_sequence_number == last_seq_r + 1'b1)
    else $error("sequence number did not advance by one");

  a_no_intake_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_item_kind && out_last) |-> in_stall)
    else $error("frame request taken during a flush");

endmodule

bind adc_sample_batch_packetizer asbp_checker u_asbp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_item_kind       (out_item_kind),
  .out_sequence_number (out_sequence_number),
  .out_offset_ms       (out_offset_ms),
  .out_last            (out_last)
);
